[sv/sma_pkg.sv]
`timescale 1ns / 1ps

package sma_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int BIN_IDX_W    = 12;
  localparam int FFT_SIZE_W   = 13;
  localparam int FFT_SIZE_RST = 1024;
  localparam int SAMPLE_MAX   = 8388607;
  localparam int SAMPLE_MIN   = -8388608;

  // tdata of the result channel: average, then bin_index, padded to bytes
  localparam int OUT_DATA_W = ((SAMPLE_W + BIN_IDX_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_FFT_SIZE = '0;

endpackage

[sv/spectrum_moving_average.sv]
`timescale 1ns / 1ps

// Per-bin moving average of spectrum frames.
// in_*  : one bin sample per transfer (tdata = sample, Q8.16 signed).
// out_* : one result per input transfer, in order; tdata = average (Q8.16)
//         then bin_index, tlast marks the last bin of a frame.
// cfg_* : APB-style write/read of fft_size (byte address 0); write it only
//         while the block is idle.
// Throughput: one sample per clock while out_tready is high. A sample is read
// from the frame ring and the running-sum memory at acceptance into the update
// stage; there the sum is updated and written back as the result moves into
// the output register. Back-to-back hits on the same bin (fft_size of 1) are
// served by forwarding the pending sum.
// Reset: after rst_n the block sweeps both memories to zero, one frame
// store entry per cycle, over all FRAMES*MAX_BINS entries (32768 at the defaults);
// in_tready stays low during the sweep, configuration writes are taken.
// Stall: when out_tready is low the result holds in the output register;
// one more sample is taken into the update stage, then in_tready drops.
module spectrum_moving_average #(
  parameter int FRAMES   = 8,
  parameter int MAX_BINS = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // sample [23:0]
  input  logic [sma_pkg::SAMPLE_W-1:0]    in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // average [23:0], bin_index [35:24], zero [39:36]
  output logic [sma_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [sma_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [sma_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [sma_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  import sma_pkg::*;

  localparam int BW    = $clog2(MAX_BINS);
  localparam int FD    = FRAMES * MAX_BINS;
  localparam int FAW   = $clog2(FD);
  localparam int SUMW  = SAMPLE_W + $clog2(FRAMES);
  localparam int SHIFT = $clog2(FRAMES + 1) - 1;
  localparam int CW    = (FFT_SIZE_W > BW + 1) ? FFT_SIZE_W : BW + 1;
  localparam logic [FAW-1:0] LAST_BASE = FAW'((FRAMES - 1) * MAX_BINS);
  localparam logic signed [SUMW-1:0] AVG_MAX = SUMW'(SAMPLE_MAX);
  localparam logic signed [SUMW-1:0] AVG_MIN = SUMW'(SAMPLE_MIN);

  // memories
  logic signed [SAMPLE_W-1:0] frame_mem [FD];
  logic signed [SUMW-1:0]     sum_mem   [MAX_BINS];

  // configuration
  logic [FFT_SIZE_W-1:0] fft_size_r;
  logic                  cfg_wr;

  // clearing sweep
  logic           clr_active_r;
  logic [FAW-1:0] clr_addr_r;
  logic [BW-1:0]  clr_bin_r;

  // frame position
  logic [BW-1:0]  bin_cnt_r;
  logic [FAW-1:0] base_r;
  logic [CW-1:0]  size_eff;
  logic           in_last;
  logic [FAW-1:0] in_pos;

  // update stage
  logic                       s1_valid_r;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic [BW-1:0]              s1_bin_r;
  logic                       s1_last_r;
  logic                       s1_fwd_r;
  logic signed [SUMW-1:0]     s1_fwd_sum_r;
  logic signed [SAMPLE_W-1:0] s1_old_r;
  logic signed [SUMW-1:0]     s1_sum_rd_r;
  logic signed [SUMW-1:0]     new_sum;
  logic signed [SUMW-1:0]     shifted;
  logic signed [SUMW-1:0]     clamped;
  logic                       s1_move;
  logic                       in_accept;

  // output register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] avg_r;
  logic [BIN_IDX_W-1:0]       bin_idx_r;
  logic                       last_r;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_ADDR_W-1:2] == REG_FFT_SIZE) begin
      cfg_prdata = CFG_DATA_W'(fft_size_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fft_size_r <= FFT_SIZE_W'(FFT_SIZE_RST);
    end else if (cfg_wr && cfg_paddr[CFG_ADDR_W-1:2] == REG_FFT_SIZE) begin
      fft_size_r <= cfg_pwdata[FFT_SIZE_W-1:0];
    end
  end

  // ---------------- handshake ----------------
  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clr_active_r && (!s1_valid_r || s1_move);
  assign in_accept = in_tvalid && in_tready;

  // ---------------- frame position ----------------
  always_comb begin
    size_eff = CW'(fft_size_r);
    if (fft_size_r == '0) begin
      size_eff = CW'(1);
    end else if (CW'(fft_size_r) > CW'(MAX_BINS)) begin
      size_eff = CW'(MAX_BINS);
    end
  end

  assign in_last = CW'(bin_cnt_r) >= (size_eff - CW'(1));
  assign in_pos  = base_r + FAW'(bin_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r <= '0;
      base_r    <= '0;
    end else if (in_accept) begin
      if (in_last) begin
        bin_cnt_r <= '0;
        base_r    <= (base_r == LAST_BASE) ? '0 : base_r + FAW'(MAX_BINS);
      end else begin
        bin_cnt_r <= bin_cnt_r + BW'(1);
      end
    end
  end

  // ---------------- clearing sweep ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      clr_bin_r    <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + FAW'(1);
      if (clr_bin_r != BW'(MAX_BINS - 1)) begin
        clr_bin_r <= clr_bin_r + BW'(1);
      end
      if (clr_addr_r == FAW'(FD - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // ---------------- frame ring ----------------
  // Read the old value and store the new sample at the same edge.
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      frame_mem[clr_addr_r] <= '0;
    end else if (in_accept) begin
      frame_mem[in_pos] <= signed'(in_tdata);
    end
    if (in_accept) begin
      s1_old_r <= frame_mem[in_pos];
    end
  end

  // ---------------- running sums ----------------
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      sum_mem[clr_bin_r] <= '0;
    end else if (s1_move) begin
      sum_mem[s1_bin_r] <= new_sum;
    end
    if (in_accept) begin
      s1_sum_rd_r <= sum_mem[bin_cnt_r];
    end
  end

  // ---------------- update stage ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample_r  <= signed'(in_tdata);
      s1_bin_r     <= bin_cnt_r;
      s1_last_r    <= in_last;
      // the write-back of the previous item lands after this read
      s1_fwd_r     <= s1_move && (s1_bin_r == bin_cnt_r);
      s1_fwd_sum_r <= new_sum;
    end
  end

  always_comb begin
    new_sum = (s1_fwd_r ? s1_fwd_sum_r : s1_sum_rd_r)
              + SUMW'(s1_sample_r) - SUMW'(s1_old_r);
    shifted = new_sum >>> SHIFT;
    clamped = shifted;
    if (shifted > AVG_MAX) begin
      clamped = AVG_MAX;
    end else if (shifted < AVG_MIN) begin
      clamped = AVG_MIN;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      avg_r     <= SAMPLE_W'(clamped);
      bin_idx_r <= BIN_IDX_W'(s1_bin_r);
      last_r    <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {{(OUT_DATA_W - SAMPLE_W - BIN_IDX_W){1'b0}}, bin_idx_r, avg_r};

  // ---------------- assertions ----------------
  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_tready)
    else $error("input taken during memory clearing");

  a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    bin_cnt_r <= BW'(MAX_BINS - 1))
    else $error("bin counter beyond MAX_BINS");

  a_base_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    base_r <= LAST_BASE)
    else $error("ring base beyond last slot");

  a_stage_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && !in_accept) |=> !s1_valid_r)
    else $error("update stage kept an item it already passed on");

  a_fwd_same_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && s1_move && s1_bin_r == bin_cnt_r) |=> s1_fwd_r)
    else $error("missing forward for consecutive hits on one bin");

endmodule
